// ----- design/fakt_pkg.sv -----
`default_nettype none
package fakt_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int NUM_JOINTS = 9;
  localparam int NCOORD = 9;

  typedef struct packed {
    logic action;
    logic signed [31:0] coord_in_0;
    logic signed [31:0] coord_in_1;
    logic signed [31:0] coord_in_2;
    logic signed [31:0] coord_in_3;
    logic signed [31:0] coord_in_4;
    logic signed [31:0] coord_in_5;
    logic signed [31:0] coord_in_6;
    logic signed [31:0] coord_in_7;
    logic signed [31:0] coord_in_8;
  } fakt_in_t;

  typedef struct packed {
    logic signed [31:0] coord_out_0;
    logic signed [31:0] coord_out_1;
    logic signed [31:0] coord_out_2;
    logic signed [31:0] coord_out_3;
    logic signed [31:0] coord_out_4;
    logic signed [31:0] coord_out_5;
    logic signed [31:0] coord_out_6;
    logic signed [31:0] coord_out_7;
    logic signed [31:0] coord_out_8;
  } fakt_out_t;

  typedef struct packed {
    logic kinematics_mode;
    logic signed [31:0] pivot_x;
    logic signed [31:0] pivot_y;
    logic signed [31:0] pivot_z;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
    logic signed [31:0] tool_length;
    logic [35:0] joint_axis_map;
  } fakt_cfg_t;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } fakt_trig_t;

endpackage
`default_nettype wire

// ----- design/five_axis_kinematics_transform_core.sv -----
// Channel  Handshake                          Payload
// input    start, accepted while busy is low  in_item
// result   done, one-cycle strobe             result
// config   psel/penable/pwrite, pready = 1    paddr, pwdata, prdata (8-byte regs)
//
// Two sine/cosine lanes (A and C) run side by side, each with one 33x33
// multiplier, 7 setup steps and 16 series terms at 4 steps per term. busy
// holds until both lanes hand their results to an idle merge stage; a new item
// can be taken after that hand-off. The merge runs 16 steps on one multiplier,
// overlapped with the next item's lanes, and registers done in its finish state.
// Synchronous reset clears control state and loads register defaults.
// The receiver cannot stall; done marks each result for one cycle only.
`default_nettype none
module five_axis_kinematics_transform_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  fakt_pkg::fakt_in_t    in_item,
  output logic                  busy,
  output logic                  done,
  output fakt_pkg::fakt_out_t   result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [5:0]       paddr,
  input  wire logic [63:0]      pwdata,
  output logic [63:0]           prdata,
  output logic                  pready
);
  import fakt_pkg::*;

  typedef enum logic [2:0] {
    R_MODE, R_PIVOT_X, R_PIVOT_Y, R_PIVOT_Z, R_OFFSET_Y, R_OFFSET_Z,
    R_TOOL_LENGTH, R_AXIS_MAP
  } reg_t;

  fakt_cfg_t cfg;
  fakt_in_t item;
  fakt_trig_t trig_a, trig_c;
  logic accept, hand;
  logic busy_a, busy_c, done_a, done_c, m_busy;
  logic signed [31:0] ang_c;
  reg_t widx;

  assign pready = 1'b1;
  assign accept = start && !busy;
  assign busy = busy_a || busy_c;
  assign hand = done_a && done_c && !m_busy;
  assign ang_c = in_item.action ? in_item.coord_in_5 : in_item.coord_in_4;
  assign widx = reg_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (accept) item <= in_item;
    if (rst) begin
      cfg.kinematics_mode <= 1'b0;
      cfg.pivot_x <= '0;
      cfg.pivot_y <= '0;
      cfg.pivot_z <= '0;
      cfg.offset_y <= '0;
      cfg.offset_z <= '0;
      cfg.tool_length <= '0;
      cfg.joint_axis_map <= 36'h876543210;
    end else if (psel && penable && pwrite) begin
      case (widx)
        R_MODE:        cfg.kinematics_mode <= pwdata[0];
        R_PIVOT_X:     cfg.pivot_x <= pwdata[31:0];
        R_PIVOT_Y:     cfg.pivot_y <= pwdata[31:0];
        R_PIVOT_Z:     cfg.pivot_z <= pwdata[31:0];
        R_OFFSET_Y:    cfg.offset_y <= pwdata[31:0];
        R_OFFSET_Z:    cfg.offset_z <= pwdata[31:0];
        R_TOOL_LENGTH: cfg.tool_length <= pwdata[31:0];
        default:       cfg.joint_axis_map <= pwdata[35:0];
      endcase
    end
  end

  always_comb begin
    case (widx)
      R_MODE:        prdata = 64'(cfg.kinematics_mode);
      R_PIVOT_X:     prdata = 64'(unsigned'(cfg.pivot_x));
      R_PIVOT_Y:     prdata = 64'(unsigned'(cfg.pivot_y));
      R_PIVOT_Z:     prdata = 64'(unsigned'(cfg.pivot_z));
      R_OFFSET_Y:    prdata = 64'(unsigned'(cfg.offset_y));
      R_OFFSET_Z:    prdata = 64'(unsigned'(cfg.offset_z));
      R_TOOL_LENGTH: prdata = 64'(unsigned'(cfg.tool_length));
      default:       prdata = 64'(cfg.joint_axis_map);
    endcase
  end

  fakt_trig_lane u_lane_a (
    .clk  (clk),
    .rst  (rst),
    .go   (accept),
    .ack  (hand),
    .ang  (in_item.coord_in_3),
    .busy (busy_a),
    .done (done_a),
    .trig (trig_a)
  );

  fakt_trig_lane u_lane_c (
    .clk  (clk),
    .rst  (rst),
    .go   (accept),
    .ack  (hand),
    .ang  (ang_c),
    .busy (busy_c),
    .done (done_c),
    .trig (trig_c)
  );

  fakt_merge u_merge (
    .clk    (clk),
    .rst    (rst),
    .start  (hand),
    .item   (item),
    .cfg    (cfg),
    .trig_a (trig_a),
    .trig_c (trig_c),
    .busy   (m_busy),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

// ----- design/fakt_trig_lane.sv -----
`default_nettype none
module fakt_trig_lane (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic               ack,
  input  wire logic signed [31:0] ang,
  output logic                    busy,
  output logic                    done,
  output fakt_pkg::fakt_trig_t    trig
);
  import fakt_pkg::*;

  localparam int ASH = FRACTION_BITS + 1;
  localparam int QBIAS = (2 ** (30 - FRACTION_BITS)) / 45 + 1;
  localparam int BIAS = 45 * QBIAS;
  localparam logic [32:0] M45 = 33'd6108397932;
  localparam logic [5:0] SH45 = 6'd38;
  localparam logic [8:0] K45 = 9'd45;
  localparam logic [32:0] K_HALF_PI = 33'd1686629713;
  localparam logic [32:0] ONE_Q30 = 33'd1 << 30;

  typedef struct packed {
    logic [8:0]  k;
    logic [5:0]  sh;
    logic [32:0] m;
  } ser_t;

  typedef enum logic [3:0] {
    S_IDLE, S_QMUL, S_QFIX, S_XMUL, S_XH, S_XHFIX, S_XLMUL, S_XLFIX,
    S_M1, S_M2, S_M3, S_M4, S_DONE
  } state_t;

  function automatic ser_t ser_of(input logic cos_ph, input logic [2:0] j);
    ser_t s;
    case ({cos_ph, j})
      4'd0:  s = '{9'd6,   6'd35, 33'd5726623061};
      4'd1:  s = '{9'd20,  6'd37, 33'd6871947673};
      4'd2:  s = '{9'd42,  6'd38, 33'd6544712070};
      4'd3:  s = '{9'd72,  6'd39, 33'd7635497415};
      4'd4:  s = '{9'd110, 6'd39, 33'd4997780126};
      4'd5:  s = '{9'd156, 6'd40, 33'd7048151460};
      4'd6:  s = '{9'd210, 6'd40, 33'd5235769656};
      4'd7:  s = '{9'd272, 6'd41, 33'd8084644321};
      4'd8:  s = '{9'd2,   6'd33, 33'd4294967296};
      4'd9:  s = '{9'd12,  6'd36, 33'd5726623061};
      4'd10: s = '{9'd30,  6'd37, 33'd4581298449};
      4'd11: s = '{9'd56,  6'd38, 33'd4908534052};
      4'd12: s = '{9'd90,  6'd39, 33'd6108397932};
      4'd13: s = '{9'd132, 6'd40, 33'd8329633543};
      4'd14: s = '{9'd182, 6'd40, 33'd6041272680};
      default: s = '{9'd240, 6'd40, 33'd4581298449};
    endcase
    return s;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v < 36'sd0) r = 32'sd0;
    else if (v > $signed({3'b0, ONE_Q30})) r = 32'sd1073741824;
    else r = v[31:0];
    return r;
  endfunction

  state_t st;
  logic [65:0] prod;
  logic [32:0] vq, x, t, qh;
  logic [ASH-1:0] lo;
  logic [19:0] nl;
  logic [1:0] quad;
  logic [2:0] j;
  logic cos_ph;
  logic signed [35:0] acc;
  logic signed [31:0] sres;

  logic [32:0] mul_a, mul_b;
  logic [5:0] div_sh;
  logic [8:0] div_k;
  logic [32:0] div_q0, div_r0, div_q, div_r;
  logic signed [32:0] qv;
  logic [36:0] nfull;
  ser_t ser;
  logic signed [35:0] accn;
  logic signed [31:0] cres;
  logic [32:0] xv;

  always_comb begin
    ser = ser_of(cos_ph, j);
    qv = ($signed({ang[31], ang}) >>> ASH) + $signed(33'(BIAS));
    nfull = prod[ASH+36:ASH];
    mul_a = '0;
    mul_b = '0;
    case (st)
      S_QMUL: begin
        mul_a = vq;
        mul_b = M45;
      end
      S_XMUL: begin
        mul_a = vq;
        mul_b = K_HALF_PI;
      end
      S_XH: begin
        mul_a = 33'(nfull[36:20]);
        mul_b = M45;
      end
      S_XLMUL: begin
        mul_a = vq;
        mul_b = M45;
      end
      S_M1: begin
        mul_a = t;
        mul_b = x;
      end
      S_M2: begin
        mul_a = prod[62:30];
        mul_b = x;
      end
      S_M3: begin
        mul_a = prod[62:30];
        mul_b = ser.m;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    if (st == S_M4) begin
      div_sh = ser.sh;
      div_k = ser.k;
    end else begin
      div_sh = SH45;
      div_k = K45;
    end
    div_q0 = 33'(prod >> div_sh);
    div_r0 = vq - 33'(div_q0 * 33'(div_k));
    if (div_r0 >= 33'(div_k)) begin
      div_q = div_q0 + 33'd1;
      div_r = div_r0 - 33'(div_k);
    end else begin
      div_q = div_q0;
      div_r = div_r0;
    end
    accn = j[0] ? acc + $signed({3'b0, div_q}) : acc - $signed({3'b0, div_q});
    cres = clamp_q30(accn);
    xv = (qh << 20) + div_q;
  end

  always_ff @(posedge clk) begin
    prod <= 66'(mul_a) * 66'(mul_b);
    if (rst) begin
      st <= S_IDLE;
    end else begin
      case (st)
        S_IDLE: begin
          if (go) begin
            vq <= 33'(qv);
            lo <= ang[ASH-1:0];
            st <= S_QMUL;
          end
        end
        S_QMUL: st <= S_QFIX;
        S_QFIX: begin
          quad <= 2'(div_q - 33'(QBIAS));
          vq <= 33'({div_r[5:0], lo});
          st <= S_XMUL;
        end
        S_XMUL: st <= S_XH;
        S_XH: begin
          vq <= 33'(nfull[36:20]);
          nl <= nfull[19:0];
          st <= S_XHFIX;
        end
        S_XHFIX: begin
          qh <= div_q;
          vq <= 33'({div_r[5:0], nl});
          st <= S_XLMUL;
        end
        S_XLMUL: st <= S_XLFIX;
        S_XLFIX: begin
          x <= xv;
          t <= xv;
          acc <= $signed({3'b0, xv});
          j <= '0;
          cos_ph <= 1'b0;
          st <= S_M1;
        end
        S_M1: st <= S_M2;
        S_M2: st <= S_M3;
        S_M3: begin
          vq <= prod[62:30];
          st <= S_M4;
        end
        S_M4: begin
          if (j == 3'd7) begin
            if (!cos_ph) begin
              sres <= cres;
              cos_ph <= 1'b1;
              t <= ONE_Q30;
              acc <= $signed({3'b0, ONE_Q30});
              j <= '0;
              st <= S_M1;
            end else begin
              case (quad)
                2'd0: begin
                  trig.sn <= sres;
                  trig.cs <= cres;
                end
                2'd1: begin
                  trig.sn <= cres;
                  trig.cs <= -sres;
                end
                2'd2: begin
                  trig.sn <= -sres;
                  trig.cs <= -cres;
                end
                default: begin
                  trig.sn <= -cres;
                  trig.cs <= sres;
                end
              endcase
              st <= S_DONE;
            end
          end else begin
            j <= j + 3'd1;
            t <= div_q;
            acc <= accn;
            st <= S_M1;
          end
        end
        S_DONE: begin
          if (ack) st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign busy = (st != S_IDLE);
  assign done = (st == S_DONE);

endmodule
`default_nettype wire

// ----- design/fakt_merge.sv -----
`default_nettype none
module fakt_merge (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  fakt_pkg::fakt_in_t    item,
  input  fakt_pkg::fakt_cfg_t   cfg,
  input  fakt_pkg::fakt_trig_t  trig_a,
  input  fakt_pkg::fakt_trig_t  trig_c,
  output logic                  busy,
  output logic                  done,
  output fakt_pkg::fakt_out_t   result
);
  import fakt_pkg::*;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_TAIL, M_FIN} state_t;
  typedef enum logic [2:0] {
    P_SA, P_CA, P_SC, P_CC, P_SCCA, P_SCSA, P_CCCA, P_CCSA
  } psel_t;
  typedef enum logic [2:0] {V_E0, V_E1, V_E2, V_DY, V_DZ, V_CA, V_SA} vsel_t;
  typedef enum logic [2:0] {
    D_ACC0, D_ACC1, D_ACC2, D_SCCA, D_SCSA, D_CCCA, D_CCSA
  } dst_t;
  typedef struct packed {
    logic  vld;
    psel_t p;
    vsel_t v;
    dst_t  d;
    logic  neg;
  } step_t;

  function automatic step_t step_of(input logic inv, input logic [3:0] j);
    step_t s;
    s = '{1'b0, P_SA, V_E0, D_ACC0, 1'b0};
    case (j)
      4'd0:  s = '{1'b1, P_SC, V_CA, D_SCCA, 1'b0};
      4'd1:  s = '{1'b1, P_SC, V_SA, D_SCSA, 1'b0};
      4'd2:  s = '{1'b1, P_CC, V_CA, D_CCCA, 1'b0};
      4'd3:  s = '{1'b1, P_CC, V_SA, D_CCSA, 1'b0};
      4'd4:  s = '{1'b1, P_CC, V_E0, D_ACC0, 1'b0};
      4'd9:  s = '{1'b1, P_CA, V_E2, D_ACC2, 1'b0};
      default: s = '{1'b0, P_SA, V_E0, D_ACC0, 1'b0};
    endcase
    if (!inv) begin
      case (j)
        4'd5:  s = '{1'b1, P_SC,   V_DY, D_ACC0, 1'b0};
        4'd6:  s = '{1'b1, P_SC,   V_E0, D_ACC1, 1'b1};
        4'd7:  s = '{1'b1, P_CC,   V_DY, D_ACC1, 1'b0};
        4'd8:  s = '{1'b1, P_SA,   V_E1, D_ACC2, 1'b1};
        4'd10: s = '{1'b1, P_SCCA, V_E1, D_ACC0, 1'b0};
        4'd11: s = '{1'b1, P_SCSA, V_E2, D_ACC0, 1'b0};
        4'd12: s = '{1'b1, P_CCCA, V_E1, D_ACC1, 1'b0};
        4'd13: s = '{1'b1, P_CCSA, V_E2, D_ACC1, 1'b0};
        default: s = s;
      endcase
    end else begin
      case (j)
        4'd5:  s = '{1'b1, P_SC,   V_E1, D_ACC0, 1'b1};
        4'd6:  s = '{1'b1, P_SA,   V_E2, D_ACC1, 1'b1};
        4'd7:  s = '{1'b1, P_CA,   V_DY, D_ACC1, 1'b1};
        4'd8:  s = '{1'b1, P_SA,   V_DZ, D_ACC1, 1'b0};
        4'd10: s = '{1'b1, P_SCCA, V_E0, D_ACC1, 1'b0};
        4'd11: s = '{1'b1, P_SCSA, V_E0, D_ACC2, 1'b0};
        4'd12: s = '{1'b1, P_CCCA, V_E1, D_ACC1, 1'b0};
        4'd13: s = '{1'b1, P_CCSA, V_E1, D_ACC2, 1'b0};
        4'd14: s = '{1'b1, P_SA,   V_DY, D_ACC2, 1'b1};
        4'd15: s = '{1'b1, P_CA,   V_DZ, D_ACC2, 1'b1};
        default: s = s;
      endcase
    end
    return s;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  state_t st;
  logic [3:0] j;
  fakt_in_t it;
  logic inv;
  logic signed [31:0] sa, ca, sc, cc, scca, scsa, ccca, ccsa, dy;
  logic signed [32:0] dz;
  logic signed [34:0] e0, e1, e2;
  logic signed [39:0] acc0, acc1, acc2;
  logic [64:0] p_mag;
  logic p_neg, p_vld;
  dst_t p_dst;

  step_t stp;
  logic signed [31:0] pv;
  logic signed [34:0] vv;
  logic [30:0] pm;
  logic [33:0] vm;
  logic [34:0] rr;
  logic signed [39:0] sv;
  logic signed [31:0] cin [NCOORD];
  logic signed [31:0] res [NCOORD];
  logic signed [31:0] icin [NCOORD];
  logic signed [32:0] dz_in;
  logic signed [31:0] c_px, c_py, c_pz, c_dy;
  logic [3:0] code;

  always_comb begin
    stp = step_of(inv, j);
    case (stp.p)
      P_SA:    pv = sa;
      P_CA:    pv = ca;
      P_SC:    pv = sc;
      P_CC:    pv = cc;
      P_SCCA:  pv = scca;
      P_SCSA:  pv = scsa;
      P_CCCA:  pv = ccca;
      default: pv = ccsa;
    endcase
    case (stp.v)
      V_E0:    vv = e0;
      V_E1:    vv = e1;
      V_E2:    vv = e2;
      V_DY:    vv = 35'(dy);
      V_DZ:    vv = 35'(dz);
      V_CA:    vv = 35'(ca);
      default: vv = 35'(sa);
    endcase
    pm = 31'(pv < 0 ? -pv : pv);
    vm = 34'(vv < 0 ? -vv : vv);
    rr = 35'((p_mag + (65'd1 << 29)) >> 30);
    sv = p_neg ? -$signed({5'b0, rr}) : $signed({5'b0, rr});

    c_px = cfg.pivot_x;
    c_py = cfg.pivot_y;
    c_pz = cfg.pivot_z;
    c_dy = cfg.offset_y;
    dz_in = 33'(cfg.offset_z) + 33'(cfg.tool_length);
    icin = '{item.coord_in_0, item.coord_in_1, item.coord_in_2, item.coord_in_3,
             item.coord_in_4, item.coord_in_5, item.coord_in_6, item.coord_in_7,
             item.coord_in_8};
    cin = '{it.coord_in_0, it.coord_in_1, it.coord_in_2, it.coord_in_3,
            it.coord_in_4, it.coord_in_5, it.coord_in_6, it.coord_in_7,
            it.coord_in_8};

    for (int i = 0; i < NCOORD; i++) res[i] = '0;
    code = '0;
    if (!cfg.kinematics_mode) begin
      for (int i = 0; i < NUM_JOINTS && i < NCOORD; i++) begin
        code = cfg.joint_axis_map[4*i +: 4];
        if (code <= 4'd8) begin
          if (inv) res[i] = cin[code];
          else res[code] = cin[i];
        end
      end
    end else begin
      res[0] = sat32(acc0);
      res[1] = sat32(acc1);
      res[2] = sat32(acc2);
      res[3] = cin[3];
      if (inv) res[4] = cin[5];
      else res[5] = cin[4];
    end
  end

  always_ff @(posedge clk) begin
    p_mag <= 65'(pm) * 65'(vm);
    p_neg <= (pv < 0) ^ (vv < 0) ^ stp.neg;
    p_dst <= stp.d;
    if (p_vld) begin
      case (p_dst)
        D_ACC0:  acc0 <= acc0 + sv;
        D_ACC1:  acc1 <= acc1 + sv;
        D_ACC2:  acc2 <= acc2 + sv;
        D_SCCA:  scca <= sv[31:0];
        D_SCSA:  scsa <= sv[31:0];
        D_CCCA:  ccca <= sv[31:0];
        default: ccsa <= sv[31:0];
      endcase
    end
    if (st == M_IDLE && start) begin
      it <= item;
      inv <= item.action;
      sa <= trig_a.sn;
      ca <= trig_a.cs;
      sc <= trig_c.sn;
      cc <= trig_c.cs;
      dy <= c_dy;
      dz <= dz_in;
      e0 <= 35'(icin[0]) - 35'(c_px);
      if (item.action) begin
        e1 <= 35'(icin[1]) - 35'(c_py);
        e2 <= 35'(icin[2]) - 35'(c_pz);
        acc1 <= 40'(c_dy) + 40'(c_py);
      end else begin
        e1 <= 35'(icin[1]) - 35'(c_dy) - 35'(c_py);
        e2 <= 35'(icin[2]) - 35'(dz_in) - 35'(c_pz);
        acc1 <= 40'(c_py);
      end
      acc0 <= 40'(c_px);
      acc2 <= 40'(dz_in) + 40'(c_pz);
    end
    if (st == M_FIN) begin
      result <= '{res[0], res[1], res[2], res[3], res[4], res[5], res[6],
                  res[7], res[8]};
    end
    if (rst) begin
      st <= M_IDLE;
      j <= '0;
      p_vld <= 1'b0;
      done <= 1'b0;
    end else begin
      p_vld <= (st == M_RUN) && stp.vld;
      done <= (st == M_FIN);
      case (st)
        M_IDLE: begin
          if (start) begin
            j <= '0;
            st <= M_RUN;
          end
        end
        M_RUN: begin
          j <= j + 4'd1;
          if (j == 4'd15) st <= M_TAIL;
        end
        M_TAIL: st <= M_FIN;
        M_FIN: st <= M_IDLE;
        default: st <= M_IDLE;
      endcase
    end
  end

  assign busy = (st != M_IDLE);

endmodule
`default_nettype wire

// ----- verif/tb_five_axis_kinematics_transform_core.sv -----
`timescale 1ns / 1ps
module tb_five_axis_kinematics_transform_core;
  import fakt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_PIVOT_X = 3'd1,
    REG_PIVOT_Y = 3'd2,
    REG_PIVOT_Z = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5,
    REG_TOOL_LENGTH = 3'd6,
    REG_AXIS_MAP = 3'd7
  } reg_idx_e;

  typedef enum logic {MODE_MAP = 1'b0, MODE_TABLE = 1'b1} kin_mode_e;
  typedef enum logic {ACT_FORWARD = 1'b0, ACT_INVERSE = 1'b1} action_e;

  localparam logic [35:0] IDENTITY_MAP = 36'h876543210;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  fakt_in_t in_item = '0;
  logic busy;
  logic done;
  fakt_out_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  five_axis_kinematics_transform_core i_dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  fakt_cfg_t shadow_cfg;
  fakt_out_t expected_coords[$];
  int mismatch_count = 0;
  int result_count = 0;
  int item_count = 0;
  int idle_cycles = 0;
  int table_items = 0;
  int map_items = 0;

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint mul_q30(longint p, longint v);
    logic neg;
    logic [63:0] mp, mv, r;
    neg = (p < 0) != (v < 0);
    mp = p < 0 ? -p : p;
    mv = v < 0 ? -v : v;
    r = (mp * mv + (64'd1 << 29)) >> 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > (longint'(1) << 30)) return longint'(1) << 30;
    return v;
  endfunction

  function automatic fakt_trig_t sin_cos_deg(longint ang);
    longint d, q, r, s, c;
    logic [63:0] x, t;
    fakt_trig_t sc;
    d = longint'(90) << FRACTION_BITS;
    q = ang / d;
    r = ang % d;
    if (r < 0) begin
      r += d;
      q -= 1;
    end
    x = (64'(r) * 64'd1686629713) / 64'(d);
    t = x;
    s = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      t = ((((t * x) >> 30) * x) >> 30) / 64'((2 * n) * (2 * n + 1));
      s += (n & 1) ? -longint'(t) : longint'(t);
    end
    t = 64'd1 << 30;
    c = longint'(1) << 30;
    for (int n = 1; n <= 8; n++) begin
      t = ((((t * x) >> 30) * x) >> 30) / 64'((2 * n - 1) * (2 * n));
      c += (n & 1) ? -longint'(t) : longint'(t);
    end
    s = clamp_unit(s);
    c = clamp_unit(c);
    case (q & 3)
      0: begin sc.sn = 32'(s); sc.cs = 32'(c); end
      1: begin sc.sn = 32'(c); sc.cs = 32'(-s); end
      2: begin sc.sn = 32'(-s); sc.cs = 32'(-c); end
      default: begin sc.sn = 32'(-c); sc.cs = 32'(s); end
    endcase
    return sc;
  endfunction

  function automatic fakt_out_t transform_coords(fakt_in_t it, fakt_cfg_t cfg);
    longint c[9];
    longint r[9];
    longint px, py, pz, dy, dz, a, cang, sa, ca, sc, cc, scca, scsa, ccca, ccsa;
    longint ex, ey, ez;
    logic [3:0] code;
    fakt_trig_t ta, tc;
    fakt_out_t o;
    c = '{it.coord_in_0, it.coord_in_1, it.coord_in_2, it.coord_in_3, it.coord_in_4,
          it.coord_in_5, it.coord_in_6, it.coord_in_7, it.coord_in_8};
    r = '{default: 0};
    if (cfg.kinematics_mode == MODE_MAP) begin
      for (int i = 0; i < NUM_JOINTS && i < NCOORD; i++) begin
        code = cfg.joint_axis_map[4*i +: 4];
        if (code <= 8) begin
          if (it.action == ACT_INVERSE) r[i] = c[code];
          else r[code] = c[i];
        end
      end
    end else begin
      px = cfg.pivot_x;
      py = cfg.pivot_y;
      pz = cfg.pivot_z;
      dy = cfg.offset_y;
      dz = longint'(cfg.offset_z) + longint'(cfg.tool_length);
      a = c[3];
      cang = it.action == ACT_INVERSE ? c[5] : c[4];
      ta = sin_cos_deg(a);
      tc = sin_cos_deg(cang);
      sa = ta.sn; ca = ta.cs; sc = tc.sn; cc = tc.cs;
      scca = mul_q30(sc, ca);
      scsa = mul_q30(sc, sa);
      ccca = mul_q30(cc, ca);
      ccsa = mul_q30(cc, sa);
      if (it.action == ACT_FORWARD) begin
        ex = c[0] - px;
        ey = c[1] - dy - py;
        ez = c[2] - dz - pz;
        r[0] = mul_q30(cc, ex) + mul_q30(scca, ey) + mul_q30(scsa, ez) + mul_q30(sc, dy) + px;
        r[1] = -mul_q30(sc, ex) + mul_q30(ccca, ey) + mul_q30(ccsa, ez)
               + mul_q30(cc, dy) + py;
        r[2] = -mul_q30(sa, ey) + mul_q30(ca, ez) + dz + pz;
        r[3] = a;
        r[5] = cang;
      end else begin
        ex = c[0] - px;
        ey = c[1] - py;
        ez = c[2] - pz;
        r[0] = mul_q30(cc, ex) - mul_q30(sc, ey) + px;
        r[1] = mul_q30(scca, ex) + mul_q30(ccca, ey) - mul_q30(sa, ez)
               - mul_q30(ca, dy) + mul_q30(sa, dz) + dy + py;
        r[2] = mul_q30(scsa, ex) + mul_q30(ccsa, ey) + mul_q30(ca, ez)
               - mul_q30(sa, dy) - mul_q30(ca, dz) + dz + pz;
        r[3] = a;
        r[4] = cang;
      end
    end
    o.coord_out_0 = sat32(r[0]);
    o.coord_out_1 = sat32(r[1]);
    o.coord_out_2 = sat32(r[2]);
    o.coord_out_3 = sat32(r[3]);
    o.coord_out_4 = sat32(r[4]);
    o.coord_out_5 = sat32(r[5]);
    o.coord_out_6 = sat32(r[6]);
    o.coord_out_7 = sat32(r[7]);
    o.coord_out_8 = sat32(r[8]);
    return o;
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      fakt_out_t want;
      result_count++;
      if (expected_coords.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", result);
      end else begin
        want = expected_coords.pop_front();
        if (result !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %h got %h", want, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE: shadow_cfg.kinematics_mode = value[0];
      REG_PIVOT_X: shadow_cfg.pivot_x = value[31:0];
      REG_PIVOT_Y: shadow_cfg.pivot_y = value[31:0];
      REG_PIVOT_Z: shadow_cfg.pivot_z = value[31:0];
      REG_OFFSET_Y: shadow_cfg.offset_y = value[31:0];
      REG_OFFSET_Z: shadow_cfg.offset_z = value[31:0];
      REG_TOOL_LENGTH: shadow_cfg.tool_length = value[31:0];
      default: shadow_cfg.joint_axis_map = value[35:0];
    endcase
  endtask

  task automatic drain_results();
    while (expected_coords.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_item(fakt_in_t it, logic have_golden, fakt_out_t golden);
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (have_golden) expected_coords.push_back(golden);
    else expected_coords.push_back(transform_coords(it, shadow_cfg));
    if (shadow_cfg.kinematics_mode == MODE_TABLE) table_items++;
    else map_items++;
    item_count++;
  endtask

  task automatic send_gap();
    int gap;
    gap = $urandom_range(0, 4) == 0 ? $urandom_range(1, 100) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      default: return $signed($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return ($urandom_range(0, 8) * 45) << 16;
      default: return $signed($urandom_range(0, 1440 << 16)) - (720 << 16);
    endcase
  endfunction

  function automatic fakt_in_t rand_item();
    fakt_in_t it;
    it.action = 1'($urandom_range(0, 1));
    it.coord_in_0 = rand_coord();
    it.coord_in_1 = rand_coord();
    it.coord_in_2 = rand_coord();
    it.coord_in_3 = rand_angle();
    it.coord_in_4 = rand_angle();
    it.coord_in_5 = rand_angle();
    it.coord_in_6 = rand_coord();
    it.coord_in_7 = rand_coord();
    it.coord_in_8 = rand_coord();
    return it;
  endfunction

  function automatic logic [35:0] rand_map();
    logic [35:0] m;
    for (int i = 0; i < 9; i++)
      m[4*i +: 4] = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 8));
    return m;
  endfunction

  task automatic rand_config();
    write_reg(REG_MODE, $urandom_range(0, 1));
    write_reg(REG_PIVOT_X, $urandom_range(0, 3) == 0 ? $urandom : rand_coord());
    write_reg(REG_PIVOT_Y, rand_coord());
    write_reg(REG_PIVOT_Z, rand_coord());
    write_reg(REG_OFFSET_Y, rand_coord());
    write_reg(REG_OFFSET_Z, rand_coord());
    write_reg(REG_TOOL_LENGTH, rand_coord());
    write_reg(REG_AXIS_MAP, rand_map());
  endtask

  typedef struct {
    fakt_in_t stim;
    logic golden_valid;
    fakt_out_t golden;
  } directed_row_t;

  directed_row_t directed_rows[$];

  initial begin
    fakt_in_t it;
    fakt_out_t g;
    shadow_cfg = '0;
    shadow_cfg.joint_axis_map = IDENTITY_MAP;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    it = '{action: ACT_FORWARD, coord_in_0: 1, coord_in_1: 2, coord_in_2: 3, coord_in_3: 4,
           coord_in_4: 5, coord_in_5: 6, coord_in_6: 7, coord_in_7: 8, coord_in_8: 9};
    directed_rows.push_back('{it, 1'b1, fakt_out_t'({32'sd1, 32'sd2, 32'sd3, 32'sd4,
                              32'sd5, 32'sd6, 32'sd7, 32'sd8, 32'sd9})});
    it = '{action: ACT_INVERSE, coord_in_0: 32'h7fffffff, coord_in_1: 32'h80000000,
           coord_in_2: -1, coord_in_3: 0, coord_in_4: 32'h7fffffff, coord_in_5: 32'h80000000,
           coord_in_6: 1, coord_in_7: -1, coord_in_8: 32'h55555555};
    g = {it.coord_in_0, it.coord_in_1, it.coord_in_2, it.coord_in_3, it.coord_in_4,
         it.coord_in_5, it.coord_in_6, it.coord_in_7, it.coord_in_8};
    directed_rows.push_back('{it, 1'b1, g});
    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].stim, directed_rows[k].golden_valid, directed_rows[k].golden);
      send_gap();
    end
    start <= 1'b0;
    drain_results();

    write_reg(REG_AXIS_MAP, 36'hfff000000);
    for (int k = 0; k < 3; k++) begin
      it = rand_item();
      it.action = k[0];
      send_item(it, 1'b0, '0);
    end
    start <= 1'b0;
    drain_results();
    write_reg(REG_AXIS_MAP, 36'h9abcdef12);
    for (int k = 0; k < 2; k++) begin
      it = rand_item();
      it.action = k[0];
      send_item(it, 1'b0, '0);
    end
    start <= 1'b0;
    drain_results();

    write_reg(REG_MODE, MODE_TABLE);
    write_reg(REG_PIVOT_X, 32'h7fffffff);
    write_reg(REG_PIVOT_Y, 32'h80000000);
    write_reg(REG_PIVOT_Z, 32'h7fffffff);
    write_reg(REG_OFFSET_Y, 32'h80000000);
    write_reg(REG_OFFSET_Z, 32'h7fffffff);
    write_reg(REG_TOOL_LENGTH, 32'h7fffffff);
    for (int k = 0; k < 16; k++) begin
      it = rand_item();
      it.action = k[0];
      it.coord_in_3 = (k * 90) << 16;
      it.coord_in_4 = -(k * 45) << 16;
      it.coord_in_5 = (k * 30 - 200) << 16;
      if (k == 14) it.coord_in_3 = 32'h80000000;
      if (k == 15) it.coord_in_4 = 32'h7fffffff;
      send_item(it, 1'b0, '0);
      send_gap();
    end
    start <= 1'b0;
    drain_results();
    write_reg(REG_PIVOT_X, 0);
    write_reg(REG_PIVOT_Y, 0);
    write_reg(REG_PIVOT_Z, 0);
    write_reg(REG_OFFSET_Y, 0);
    write_reg(REG_OFFSET_Z, 0);
    write_reg(REG_TOOL_LENGTH, 0);

    for (int phase = 0; phase < 12; phase++) begin
      rand_config();
      for (int k = 0; k < 100; k++) begin
        send_item(rand_item(), 1'b0, '0);
        if ($urandom_range(0, 7) == 0) send_gap();
      end
      start <= 1'b0;
      drain_results();
    end

    $display("sent %0d items (%0d table, %0d mapping), checked %0d results",
             item_count, table_items, map_items, result_count);
    $display("covered both modes, both directions, extreme registers and angles");
    if (mismatch_count == 0 && expected_coords.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ----- files.f -----
design/fakt_pkg.sv
design/fakt_trig_lane.sv
design/fakt_merge.sv
design/five_axis_kinematics_transform_core.sv
verif/tb_five_axis_kinematics_transform_core.sv
